[rtl/msp_pkg.sv]
// shared constants, codes and types for the multi-motor step/direction generator
// no dependencies; imported by msp_channel, multi_stepper_pulse_generator and its testbench
`default_nettype none

package msp_pkg;

	// sizing
	localparam int NUM_MOTORS  = 7;
	localparam int COUNT_WIDTH = 16;
	localparam int HP_W        = 16;
	localparam int PIN_W       = 7;
	localparam int MIDX_W      = 3;
	localparam int CMP_W       = (COUNT_WIDTH > HP_W) ? COUNT_WIDTH : HP_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HP_FIRST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_MASK = 3'd7;

	// command bytes
	localparam logic [7:0] CHR_ONE     = 8'h31;
	localparam logic [7:0] CHR_STOP_LC = 8'h73;
	localparam logic [7:0] CHR_STOP_UC = 8'h53;

	// event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_START = 2'd1;
	localparam logic [1:0] EV_DIR   = 2'd2;
	localparam logic [1:0] EV_STOP  = 2'd3;

	// reset values
	localparam logic [HP_W-1:0] HP_RESET [7] = '{
		16'd400, 16'd600, 16'd500, 16'd600, 16'd600, 16'd700, 16'd1200
	};
	localparam logic [PIN_W-1:0] DIR_MASK_RESET = 7'd16;
	localparam logic [NUM_MOTORS-1:0] MOTOR_ONES = {NUM_MOTORS{1'b1}};

	// per-beat control into each channel
	typedef struct packed {
		logic en;
		logic tick;
		logic stop;
		logic run;
	} msp_chan_ctl_t;

endpackage

`default_nettype wire

[rtl/msp_channel.sv]
// one motor channel: saturating elapsed counter, toggle phase and step pin level
// depends on msp_pkg
`default_nettype none

module msp_channel
	import msp_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire msp_chan_ctl_t   ctl,
	input  wire logic [HP_W-1:0] half_period,
	output logic                 step_d
);

	logic [COUNT_WIDTH-1:0] elapsed_q;
	logic [COUNT_WIDTH-1:0] elapsed_inc;
	logic                   phase_q;
	logic                   step_q;
	logic                   toggle;

	// saturate at all ones
	assign elapsed_inc = (elapsed_q == {COUNT_WIDTH{1'b1}}) ? elapsed_q
		: elapsed_q + COUNT_WIDTH'(1);
	assign toggle = ctl.tick && ctl.run &&
		(CMP_W'(elapsed_inc) >= CMP_W'(half_period));

	always_comb begin
		step_d = step_q;
		if (ctl.stop) begin
			step_d = 1'b0;
		end else if (toggle) begin
			step_d = ~phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			phase_q   <= 1'b0;
			step_q    <= 1'b0;
		end else if (ctl.en) begin
			step_q <= step_d;
			if (ctl.tick) begin
				elapsed_q <= toggle ? '0 : elapsed_inc;
			end
			if (toggle) begin
				phase_q <= ~phase_q;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/multi_stepper_pulse_generator.sv]
// top level of the multi-motor step/direction generator: input register,
// command decode, motor state, channel array and result register
// depends on msp_pkg and msp_channel
`default_nettype none

// Seven-channel step/direction pulse generator. Each input beat is either a
// command byte (s_tuser low, byte in s_tdata) or one microsecond tick
// (s_tuser high). Bytes '1'..'7' start that motor, or flip its direction if
// it already runs; 's'/'S' stops every motor and drops all step pins, keeping
// each motor's toggle phase. Every input beat gives exactly one output beat
// with the pin levels, the running mask and the event it caused. The block
// takes one beat per clock: a beat lands in the input register, is decoded
// and applied to the motor state when it moves on, and its result is loaded
// into the output register at the end of that cycle, so throughput is one
// beat per cycle while m_tready is high. A stalled output register holds the
// input register, which then holds s_tready low.
// Half periods and the direction invert mask are written by the user through
// cfg_we, cfg_index, cfg_data only while the block is idle, which it does not enforce.

module multi_stepper_pulse_generator
	import msp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // [7:0] byte_value
	input  wire logic                  s_tuser,  // [0] action
	// result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [6:0] step_pins, [13:7] dir_pins, [20:14] running_mask,
	// [22:21] event_code, [25:23] event_motor, [31:26] zero
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [HP_W-1:0]       hp_q [NUM_MOTORS];
	logic [NUM_MOTORS-1:0] dir_mask_q;

	// input register
	logic                 s1_valid_s1;
	logic                 action_s1;
	logic [7:0]           byte_s1;
	logic                 s1_adv;
	logic                 s_accept;

	// motor state
	logic [NUM_MOTORS-1:0] running_q;
	logic [NUM_MOTORS-1:0] direction_q;
	logic [NUM_MOTORS-1:0] dir_level_q;

	// decode and next state
	logic [7:0]            byte_off;
	logic [MIDX_W-1:0]     idx;
	logic [NUM_MOTORS-1:0] sel;
	logic                  is_motor;
	logic                  is_stop;
	logic [NUM_MOTORS-1:0] running_d;
	logic [NUM_MOTORS-1:0] direction_d;
	logic [NUM_MOTORS-1:0] dir_level_d;
	logic [1:0]            code_d;
	logic [MIDX_W-1:0]     motor_d;
	logic [NUM_MOTORS-1:0] step_d;

	// result register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// handshake: input register moves on when the result register is free
	assign s1_adv   = s1_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_s1 || s1_adv;
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration port, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				hp_q[i] <= HP_RESET[i];
			end
			dir_mask_q <= DIR_MASK_RESET[NUM_MOTORS-1:0];
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				if (cfg_index == REG_HP_FIRST + CFG_IDX_W'(i)) begin
					hp_q[i] <= cfg_data[HP_W-1:0];
				end
			end
			if (cfg_index == REG_DIR_MASK) begin
				dir_mask_q <= cfg_data[NUM_MOTORS-1:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	// command decode: motor byte range and the two stop letters
	assign byte_off = byte_s1 - CHR_ONE;
	assign idx      = byte_off[MIDX_W-1:0];
	assign is_motor = !action_s1 && (byte_s1 >= CHR_ONE) &&
		(byte_off < 8'(NUM_MOTORS));
	assign is_stop  = !action_s1 &&
		((byte_s1 == CHR_STOP_LC) || (byte_s1 == CHR_STOP_UC));
	assign sel      = NUM_MOTORS'(1) << idx;

	always_comb begin
		running_d   = running_q;
		direction_d = direction_q;
		dir_level_d = dir_level_q;
		code_d      = EV_NONE;
		motor_d     = '0;
		if (is_motor) begin
			motor_d = idx;
			if ((running_q & sel) == '0) begin
				// stopped motor: start it
				running_d = running_q | sel;
				code_d    = EV_START;
			end else begin
				// running motor: flip direction, pin goes through the invert mask
				direction_d = direction_q ^ sel;
				dir_level_d = (dir_level_q & ~sel) | ((direction_d ^ dir_mask_q) & sel);
				code_d      = EV_DIR;
			end
		end else if (is_stop) begin
			running_d = '0;
			code_d    = EV_STOP;
		end
	end

	// channel array, all motors update in the same cycle
	for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_chan
		msp_chan_ctl_t ctl;

		assign ctl.en   = s1_adv;
		assign ctl.tick = s1_adv && action_s1;
		assign ctl.stop = s1_adv && is_stop;
		assign ctl.run  = running_q[g];

		msp_channel u_chan (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.half_period (hp_q[g]),
			.step_d      (step_d[g])
		);
	end

	// motor state, applied when the beat moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= '0;
			direction_q <= MOTOR_ONES;
			dir_level_q <= MOTOR_ONES;
		end else if (s1_adv) begin
			running_q   <= running_d;
			direction_q <= direction_d;
			dir_level_q <= dir_level_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= OUT_DATA_W'({motor_d, code_d, PIN_W'(running_d),
				PIN_W'(dir_level_d), PIN_W'(step_d)});
		end
	end

	// a motor that is not running never holds its step pin high
	a_step_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |-> ((step_d & ~running_d) == '0))
		else $error("step pin high on a stopped motor");

	// a stop beat leaves every motor stopped
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && is_stop) |=> (running_q == '0))
		else $error("motors still running after stop");

	// a held input register keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_adv) |=> (s1_valid_s1 && $stable(byte_s1) &&
		$stable(action_s1)))
		else $error("input register lost a beat");

	// only start and direction events name a motor
	a_event_motor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_data_q[22:21] != EV_START) &&
		(out_data_q[22:21] != EV_DIR)) |-> (out_data_q[25:23] == '0))
		else $error("motor index on an event without a motor");

endmodule

`default_nettype wire

[dv/multi_stepper_pulse_generator_tb.sv]
// self-checking testbench for the seven-channel step/direction generator
// drives command bytes and ticks, predicts every result beat and compares it
// depends on msp_pkg and multi_stepper_pulse_generator
`timescale 1ns / 100ps

module multi_stepper_pulse_generator_tb;
	import msp_pkg::*;

	// kind of input beat, carried on s_tuser
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// result beat as it sits on m_tdata, lowest field last
	typedef struct packed {
		logic [5:0]        pad;
		logic [MIDX_W-1:0] motor;
		logic [1:0]        ev;
		logic [PIN_W-1:0]  run;
		logic [PIN_W-1:0]  dir;
		logic [PIN_W-1:0]  step;
	} pin_result_t;

	// one row of the directed table; want only counts where typed is set
	typedef struct packed {
		logic        act;
		logic [7:0]  val;
		logic        typed;
		pin_result_t want;
	} stim_row_t;

	localparam pin_result_t NO_WANT   = '0;
	// pins straight after reset: all direction pins high, nothing running
	localparam pin_result_t IDLE_NONE = '{6'd0, 3'd0, EV_NONE, 7'h00, 7'h7F, 7'h00};
	localparam pin_result_t IDLE_STOP = '{6'd0, 3'd0, EV_STOP, 7'h00, 7'h7F, 7'h00};

	// directed opening: ignored bytes, stop with nothing running, starts,
	// direction flips with and without the invert bit, stop and restart
	localparam int N_DIRECTED = 24;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{ACT_TICK, 8'h00,           1'b1, IDLE_NONE},
		'{ACT_BYTE, CHR_STOP_LC,     1'b1, IDLE_STOP},
		'{ACT_BYTE, CHR_STOP_UC,     1'b1, IDLE_STOP},
		'{ACT_BYTE, CHR_ONE - 8'd1,  1'b1, IDLE_NONE},
		'{ACT_BYTE, CHR_ONE + 8'd7,  1'b1, IDLE_NONE},
		'{ACT_BYTE, 8'h00,           1'b1, IDLE_NONE},
		'{ACT_BYTE, 8'hFF,           1'b1, IDLE_NONE},
		// a tick carrying a motor byte must not start anything
		'{ACT_TICK, CHR_ONE,         1'b1, IDLE_NONE},
		'{ACT_BYTE, CHR_ONE,         1'b1,
			'{6'd0, 3'd0, EV_START, 7'h01, 7'h7F, 7'h00}},
		'{ACT_BYTE, CHR_ONE + 8'd6,  1'b1,
			'{6'd0, 3'd6, EV_START, 7'h41, 7'h7F, 7'h00}},
		'{ACT_BYTE, CHR_ONE,         1'b1,
			'{6'd0, 3'd0, EV_DIR, 7'h41, 7'h7E, 7'h00}},
		'{ACT_BYTE, CHR_ONE + 8'd4,  1'b0, NO_WANT},
		'{ACT_BYTE, CHR_ONE + 8'd4,  1'b0, NO_WANT},
		'{ACT_BYTE, CHR_ONE + 8'd1,  1'b0, NO_WANT},
		'{ACT_BYTE, CHR_ONE + 8'd2,  1'b0, NO_WANT},
		'{ACT_BYTE, CHR_ONE + 8'd3,  1'b0, NO_WANT},
		'{ACT_BYTE, CHR_ONE + 8'd5,  1'b0, NO_WANT},
		'{ACT_TICK, 8'hA5,           1'b0, NO_WANT},
		'{ACT_TICK, 8'h5A,           1'b0, NO_WANT},
		'{ACT_TICK, 8'hFF,           1'b0, NO_WANT},
		'{ACT_BYTE, CHR_STOP_LC,     1'b0, NO_WANT},
		'{ACT_BYTE, CHR_ONE + 8'd6,  1'b0, NO_WANT},
		'{ACT_TICK, 8'h00,           1'b0, NO_WANT},
		'{ACT_BYTE, CHR_ONE + 8'd6,  1'b0, NO_WANT}
	};

	localparam int RANDOM_PHASES   = 5;
	localparam int ITEMS_PER_PHASE = 100;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// shadow of the motor state, advanced once per accepted input beat
	logic [NUM_MOTORS-1:0]  run_q;
	logic [NUM_MOTORS-1:0]  dir_q;
	logic [NUM_MOTORS-1:0]  phase_q;
	logic [NUM_MOTORS-1:0]  step_q;
	logic [NUM_MOTORS-1:0]  dirpin_q;
	logic [COUNT_WIDTH-1:0] elapsed_q [NUM_MOTORS];
	logic [HP_W-1:0]        half_q [NUM_MOTORS];
	logic [PIN_W-1:0]       inv_mask_q;

	// register values for the next phase
	logic [CFG_DATA_W-1:0]  hp_plan [NUM_MOTORS];
	logic [CFG_DATA_W-1:0]  mask_plan;

	pin_result_t pending_results [$];
	int          mismatches = 0;
	// when clear, neither side inserts gaps or stalls
	logic        idle_on    = 1'b1;

	multi_stepper_pulse_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),  // [7:0] byte_value
		.s_tuser   (s_tuser),  // [0] action
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		// [6:0] step_pins, [13:7] dir_pins, [20:14] running_mask,
		// [22:21] event_code, [25:23] event_motor, [31:26] zero
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// run limit, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40) begin
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		end
	endtask

	// pin levels after one beat; updates the shadow state in place
	function automatic pin_result_t predict_pins(input logic act, input logic [7:0] val);
		pin_result_t r;
		logic [7:0]  idx;
		r    = '0;
		r.ev = EV_NONE;
		if (act == ACT_TICK) begin
			// every count advances, running or not, and sticks at all ones
			for (int i = 0; i < NUM_MOTORS; i++) begin
				if (elapsed_q[i] != '1) begin
					elapsed_q[i] = elapsed_q[i] + 1'b1;
				end
				if (run_q[i] && elapsed_q[i] >= half_q[i]) begin
					phase_q[i]   = ~phase_q[i];
					step_q[i]    = phase_q[i];
					elapsed_q[i] = '0;
				end
			end
		end else if (val >= CHR_ONE && val < CHR_ONE + NUM_MOTORS) begin
			idx = val - CHR_ONE;
			if (!run_q[idx]) begin
				run_q[idx] = 1'b1;
				r.ev       = EV_START;
			end else begin
				// invert mask only takes effect on a direction change
				dir_q[idx]    = ~dir_q[idx];
				dirpin_q[idx] = dir_q[idx] ^ inv_mask_q[idx];
				r.ev          = EV_DIR;
			end
			r.motor = idx[MIDX_W-1:0];
		end else if (val == CHR_STOP_LC || val == CHR_STOP_UC) begin
			// phase survives the stop, step pins drop
			run_q  = '0;
			step_q = '0;
			r.ev   = EV_STOP;
		end
		r.step = step_q;
		r.dir  = dirpin_q;
		r.run  = run_q;
		return r;
	endfunction

	// offer one beat after an optional gap; predict once it is taken
	task automatic apply_beat(input logic act, input logic [7:0] val, input logic typed,
			input pin_result_t want);
		int          gap;
		logic        taken;
		pin_result_t predicted;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= val;
		// handshake sampled mid-cycle, where nothing is in motion
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		predicted = predict_pins(act, val);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// drain, then write all eight registers from the plan back to back
	task automatic program_regs();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		for (int i = 0; i < NUM_MOTORS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_HP_FIRST + CFG_IDX_W'(i);
			cfg_data  <= hp_plan[i];
			half_q[i]  = hp_plan[i][HP_W-1:0];
			@(posedge clk);
		end
		cfg_index  <= REG_DIR_MASK;
		cfg_data   <= mask_plan;
		inv_mask_q  = mask_plan[PIN_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls, then compare each beat with the oldest expectation
	initial begin
		int          stall;
		logic        got_beat;
		pin_result_t seen;
		pin_result_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				got_beat = m_tvalid;
				seen     = m_tdata;
				@(posedge clk);
			end while (!got_beat);
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", seen, '0);
			end else begin
				want = pending_results.pop_front();
				if (seen.step != want.step) begin
					report_mismatch("step_pins", 32'(seen.step), 32'(want.step));
				end
				if (seen.dir != want.dir) begin
					report_mismatch("dir_pins", 32'(seen.dir), 32'(want.dir));
				end
				if (seen.run != want.run) begin
					report_mismatch("running_mask", 32'(seen.run), 32'(want.run));
				end
				if (seen.ev != want.ev) begin
					report_mismatch("event_code", 32'(seen.ev), 32'(want.ev));
				end
				if (seen.motor != want.motor) begin
					report_mismatch("event_motor", 32'(seen.motor), 32'(want.motor));
				end
				if (seen.pad != want.pad) begin
					report_mismatch("pad bits", 32'(seen.pad), 32'(want.pad));
				end
			end
		end
	end

	// stimulus: directed table, random phases under several settings, long half period
	initial begin
		int         r;
		logic       act;
		logic [7:0] val;

		// shadow state after reset; no invert applied to the direction pins yet
		run_q      = '0;
		dir_q      = MOTOR_ONES;
		phase_q    = '0;
		step_q     = '0;
		dirpin_q   = MOTOR_ONES;
		inv_mask_q = DIR_MASK_RESET;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			elapsed_q[i] = '0;
			half_q[i]    = HP_RESET[i];
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_DIRECTED; k++) begin
			apply_beat(DIRECTED_ROWS[k].act, DIRECTED_ROWS[k].val, DIRECTED_ROWS[k].typed,
				DIRECTED_ROWS[k].want);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				case (ph)
					0: begin
						// fastest legal rate on every motor
						hp_plan[i] = 16'd1;
					end
					1: begin
						// zero half period toggles on every tick
						hp_plan[i] = (i % 2 == 0) ? 16'd0 : 16'd2;
					end
					default: begin
						hp_plan[i] = 16'($urandom_range(0, 12));
					end
				endcase
			end
			case (ph)
				0:       mask_plan = 16'h0000;
				// upper bits of the word fall away, mask becomes all ones
				1:       mask_plan = 16'hFFFF;
				default: mask_plan = 16'($urandom_range(0, 16'hFFFF));
			endcase
			program_regs();
			// one phase runs with no gaps or stalls at all
			idle_on = (ph != 1);
			repeat (ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					act = ACT_TICK;
					val = 8'($urandom_range(0, 255));
				end else if (r < 85) begin
					act = ACT_BYTE;
					val = CHR_ONE + 8'($urandom_range(0, NUM_MOTORS - 1));
				end else if (r < 91) begin
					act = ACT_BYTE;
					val = $urandom_range(0, 1) ? CHR_STOP_LC : CHR_STOP_UC;
				end else begin
					// any byte, mostly ignored ones
					act = ACT_BYTE;
					val = 8'($urandom_range(0, 255));
				end
				apply_beat(act, val, 1'b0, NO_WANT);
			end
		end

		// longest half period: counts keep advancing while stopped but stay
		// far short of it, so restarted motors hold their step pins
		for (int i = 0; i < NUM_MOTORS; i++) begin
			hp_plan[i] = 16'hFFFF;
		end
		mask_plan = 16'($urandom_range(0, 16'hFFFF));
		program_regs();
		idle_on = 1'b0;
		apply_beat(ACT_BYTE, CHR_STOP_UC, 1'b0, NO_WANT);
		for (int i = 0; i < NUM_MOTORS; i++) begin
			apply_beat(ACT_BYTE, CHR_ONE + 8'(i), 1'b0, NO_WANT);
		end
		repeat (3) apply_beat(ACT_TICK, 8'h00, 1'b0, NO_WANT);
		idle_on = 1'b1;
		repeat (6) apply_beat(ACT_BYTE, CHR_ONE + 8'($urandom_range(0, 6)), 1'b0, NO_WANT);
		apply_beat(ACT_BYTE, CHR_STOP_LC, 1'b0, NO_WANT);

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// keep waiting to catch any stray result beat
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
